@@ rtl/core/dlerx_pkg.sv @@
`timescale 1ns / 1ps

package dlerx_pkg;

    localparam int DEF_BUFFER_DEPTH = 8;
    localparam int DEF_QUEUE_SLOTS  = 3;

    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_DLE = 8'h10;

    localparam int MIN_FRAME   = 3;
    localparam int ENTRY_BYTES = 6;

    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_QUEUED = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_DROP   = 2'd3;

    typedef logic [ENTRY_BYTES-1:0][7:0] t_entry;

endpackage

@@ rtl/core/dlerx_if.sv @@
`timescale 1ns / 1ps

interface dlerx_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface dlerx_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] frame_status;
    logic       cmd_valid;
    logic [7:0] cmd_code;
    logic [7:0] arg0;
    logic [7:0] arg1;
    logic [7:0] arg2;
    logic [7:0] arg3;
    logic [7:0] arg4;
    logic       queue_full;

    modport source (
        output valid, output frame_status, output cmd_valid, output cmd_code,
        output arg0, output arg1, output arg2, output arg3, output arg4,
        output queue_full, input ready
    );
    modport sink (
        input valid, input frame_status, input cmd_valid, input cmd_code,
        input arg0, input arg1, input arg2, input arg3, input arg4,
        input queue_full, output ready
    );
endinterface

@@ rtl/core/dle_stx_etx_frame_receiver.sv @@
`timescale 1ns / 1ps

// Channel  | Dir | Word
// ---------+-----+-------------------------------------------------------
// i_in     | in  | func, rx_byte
// o_out    | out | frame_status, cmd_valid, cmd_code, arg0..arg4, queue_full
//
// One result word per input word, one word per cycle sustained unless the
// output stalls; each word passes the input register, then result register.
// The frame checksum is a running sum kept per stored byte, so an ETX needs
// only one subtract and compare.
// Reset clears the deframer, the ring pointers, the full flag and the buffer.
// A stalled output holds its word; one further input word is taken into the
// input register before i_in.ready falls.

module dle_stx_etx_frame_receiver #(
    parameter int BUFFER_DEPTH = dlerx_pkg::DEF_BUFFER_DEPTH,
    parameter int QUEUE_SLOTS  = dlerx_pkg::DEF_QUEUE_SLOTS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dlerx_in_if.sink      i_in,
    dlerx_out_if.source   o_out
);
    import dlerx_pkg::*;

    localparam int IDX_W  = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 2);
    localparam int SLOT_W = $clog2(QUEUE_SLOTS);

    logic              r_in_valid;
    logic              r_func;
    logic [7:0]        r_byte;

    logic [7:0]        r_buf [BUFFER_DEPTH];
    logic [CNT_W-1:0]  r_count, n_count;
    logic [7:0]        r_sum, n_sum;
    logic [7:0]        r_last, n_last;
    logic              r_in_frame, n_in_frame;
    logic              r_esc, n_esc;
    logic              r_full, n_full;
    t_entry            r_slots [QUEUE_SLOTS];
    logic [SLOT_W-1:0] r_wr, n_wr;
    logic [SLOT_W-1:0] r_rd, n_rd;

    logic              r_out_valid;
    logic [1:0]        r_status, n_status;
    logic              r_cmd_valid, n_cmd_valid;
    t_entry            r_entry, n_entry;
    logic              r_out_full;

    logic              advance;
    logic              store;
    logic              buf_we;
    logic              push;
    logic [SLOT_W-1:0] wr_next;
    logic [SLOT_W-1:0] rd_next;
    t_entry            frame_entry;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign wr_next = (r_wr == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : r_wr + 1'b1;
    assign rd_next = (r_rd == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : r_rd + 1'b1;

    always_comb begin
        for (int i = 0; i < ENTRY_BYTES; i++) begin
            frame_entry[i] = r_buf[i];
        end
    end

    always_comb begin
        n_count     = r_count;
        n_sum       = r_sum;
        n_last      = r_last;
        n_in_frame  = r_in_frame;
        n_esc       = r_esc;
        n_full      = r_full;
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_status    = ST_NONE;
        n_cmd_valid = 1'b0;
        n_entry     = '0;
        store       = 1'b0;
        buf_we      = 1'b0;
        push        = 1'b0;

        if (r_func == FUNC_FETCH) begin
            if (r_wr != r_rd) begin
                n_cmd_valid = 1'b1;
                n_entry     = r_slots[r_rd];
                n_rd        = rd_next;
                n_full      = 1'b0;
            end
        end else begin
            priority if (r_esc) begin
                store = r_in_frame;
                n_esc = 1'b0;
            end else if (r_byte == CH_DLE) begin
                n_esc = 1'b1;
            end else if (r_byte == CH_ETX) begin
                if (r_in_frame) begin
                    n_in_frame = 1'b0;
                    if (r_count < CNT_W'(MIN_FRAME) || r_count > CNT_W'(BUFFER_DEPTH)
                            || (r_sum - r_last) != r_last) begin
                        n_status = ST_REJECT;
                    end else if (r_full || wr_next == r_rd) begin
                        n_full   = 1'b1;
                        n_status = ST_DROP;
                    end else begin
                        push     = 1'b1;
                        n_wr     = wr_next;
                        n_status = ST_QUEUED;
                    end
                end
            end else if (r_byte == CH_STX) begin
                n_count    = '0;
                n_sum      = '0;
                n_in_frame = 1'b1;
                n_esc      = 1'b0;
            end else begin
                store = r_in_frame;
            end
        end

        if (store) begin
            if (r_count < CNT_W'(BUFFER_DEPTH)) begin
                buf_we  = 1'b1;
                n_count = r_count + 1'b1;
                n_sum   = r_sum + r_byte;
                n_last  = r_byte;
            end else begin
                n_count = CNT_W'(BUFFER_DEPTH + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_func <= i_in.func;
            r_byte <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sum      <= '0;
            r_last     <= '0;
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
            r_full     <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                r_buf[i] <= '0;
            end
        end else if (advance) begin
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_last     <= n_last;
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
            r_full     <= n_full;
            r_wr       <= n_wr;
            r_rd       <= n_rd;
            if (buf_we) begin
                r_buf[r_count[IDX_W-1:0]] <= r_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && push) begin
            r_slots[r_wr] <= frame_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status    <= n_status;
            r_cmd_valid <= n_cmd_valid;
            r_entry     <= n_entry;
            r_out_full  <= n_full;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_status = r_status;
    assign o_out.cmd_valid    = r_cmd_valid;
    assign o_out.cmd_code     = r_entry[0];
    assign o_out.arg0         = r_entry[1];
    assign o_out.arg1         = r_entry[2];
    assign o_out.arg2         = r_entry[3];
    assign o_out.arg3         = r_entry[4];
    assign o_out.arg4         = r_entry[5];
    assign o_out.queue_full   = r_out_full;

endmodule
